[sv/keypad_matrix_debounce_actions_core_defines.svh]
// Assertion macros for the keypad matrix scanner core.
// No dependencies; included by the top level. Each macro expects clk and rst_n in scope.
`ifndef KEYPAD_MATRIX_DEBOUNCE_ACTIONS_CORE_DEFINES_SVH
`define KEYPAD_MATRIX_DEBOUNCE_ACTIONS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define KMDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KMDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/kmda_pkg.sv]
// Shared types and constants for the keypad matrix scanner core.
// No dependencies; imported by keypad_matrix_debounce_actions_core.
`default_nettype none

package kmda_pkg;

  localparam int ROWS  = 5;
  localparam int COLS  = 4;
  localparam int MAP_W = ROWS * COLS;

  localparam int ROW_W  = 3;
  localparam int COL_W  = 4;
  localparam int SLOT_W = 5;

  localparam int VIEW_SLOTS = 5;
  localparam int NOTE_SLOTS = 12;
  localparam int CTRL_SLOTS = 3;

  localparam int DEB_W  = 8;
  localparam int VIEW_W = VIEW_SLOTS * SLOT_W;
  localparam int NOTE_W = NOTE_SLOTS * SLOT_W;
  localparam int CTRL_W = CTRL_SLOTS * SLOT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NOTE_W;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [DEB_W-1:0] STABLE_MAX   = 8'd255;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam logic [SLOT_W-1:0] OCT_UP   = 5'd1;
  localparam logic [SLOT_W-1:0] OCT_DOWN = 5'h1f;  // -1 in two's complement

  // control slot positions
  localparam int CTRL_PLAY = 0;
  localparam int CTRL_OUP  = 1;
  localparam int CTRL_ODN  = 2;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_ROW  = 1'b1
  } in_kind_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_VIEW     = 3'd1,
    ACT_NOTE_OFF = 3'd2,
    ACT_PLAY     = 3'd3,
    ACT_OCTAVE   = 3'd4,
    ACT_NOTE_ON  = 3'd5
  } action_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_VIEW     = 2'd1,
    CFG_NOTE     = 2'd2,
    CFG_CONTROL  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    action_kind_t      kind;
    logic [SLOT_W-1:0] value;
    logic [MAP_W-1:0]  pressed;
    logic [MAP_W-1:0]  released;
  } result_t;

  // True when the key named by idx is set in edges; indices past the matrix never hit.
  function automatic logic key_hit(input logic [MAP_W-1:0] edges,
                                   input logic [SLOT_W-1:0] idx);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MAP_W; k++) begin
      if (32'(idx) == k) begin
        hit = edges[k];
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[sv/keypad_matrix_debounce_actions_core.sv]
// Keypad matrix scanner core: map assembly, debounce, edge detect, action pick.
// Depends on kmda_pkg and keypad_matrix_debounce_actions_core_defines.svh.
`default_nettype none

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | in        | in_tvalid/in_tready | tuser: kind; tdata: row, column levels
//  out_    | out       | out_tvalid/tready   | tuser: action kind; tdata: value, edges
//  cfg_    | in        | cfg_wr_en           | cfg_index, cfg_wdata (no read-back)
//
// One transaction per cycle while in_tready is high, handled in the cycle it is
// accepted; a result (if any) is registered in the output register, else the skid one.
// A two-entry output buffer (output register plus skid register) lets input keep
// flowing while a result waits; in_tready drops only when both entries are full.
// rst_n is synchronous, active low: resets maps, stable counter, config regs and buffers.

`include "keypad_matrix_debounce_actions_core_defines.svh"

module keypad_matrix_debounce_actions_core
  import kmda_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic                   in_tuser,    // [0] kind
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,    // [2:0] row_index, [6:3] column_levels

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [2:0]                  out_tuser,   // [2:0] action_kind
  output logic [OUT_TDATA_W-1:0]      out_tdata,   // [4:0] action_value,
                                                   // [24:5] pressed_edges,
                                                   // [44:25] released_edges

  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic [DEB_W-1:0]  debounce_r;
  logic [VIEW_W-1:0] view_slots_r;
  logic [NOTE_W-1:0] note_slots_r;
  logic [CTRL_W-1:0] ctrl_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      view_slots_r <= '0;
      note_slots_r <= '0;
      ctrl_slots_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE: debounce_r   <= cfg_wdata[DEB_W-1:0];
        CFG_VIEW:     view_slots_r <= cfg_wdata[VIEW_W-1:0];
        CFG_NOTE:     note_slots_r <= cfg_wdata[NOTE_W-1:0];
        CFG_CONTROL:  ctrl_slots_r <= cfg_wdata[CTRL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  logic [MAP_W-1:0] scan_map_r, scan_map_nxt;
  logic [MAP_W-1:0] prev_map_r, prev_map_nxt;
  logic [MAP_W-1:0] valid_map_r, valid_map_nxt;
  logic [DEB_W-1:0] stable_r, stable_nxt;

  logic             in_acc;
  logic             is_tick;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] levels;
  logic             row_ok;
  logic             scan_done;     // accepted sample of the last row
  logic             map_same;
  logic             map_settled;
  logic [MAP_W-1:0] down_edges;
  logic [MAP_W-1:0] up_edges;

  assign in_acc  = in_tvalid & in_tready;
  assign is_tick = (in_kind_t'(in_tuser) == KIND_TICK);
  assign row     = in_tdata[ROW_W-1:0];
  assign levels  = in_tdata[ROW_W +: COL_W];
  assign row_ok  = (32'(row) < ROWS);

  // map being assembled, including this sample
  always_comb begin
    scan_map_nxt = (32'(row) == 0) ? '0 : scan_map_r;
    for (int r = 0; r < ROWS; r++) begin
      for (int j = 0; j < COLS; j++) begin
        if (32'(row) == r && !levels[j]) begin
          scan_map_nxt[r*COLS + j] = 1'b1;
        end
      end
    end
  end

  assign scan_done   = in_acc && !is_tick && (32'(row) == ROWS - 1);
  assign map_same    = (scan_map_nxt == prev_map_r);
  assign map_settled = map_same && (stable_r >= debounce_r);

  // edges exist only while the assembled map is settled; otherwise both are zero
  assign down_edges = map_settled ? (scan_map_nxt & ~valid_map_r) : '0;
  assign up_edges   = map_settled ? (~scan_map_nxt & valid_map_r) : '0;

  always_comb begin
    stable_nxt    = stable_r;
    prev_map_nxt  = prev_map_r;
    valid_map_nxt = valid_map_r;
    if (in_acc && is_tick) begin
      if (stable_r != STABLE_MAX) begin
        stable_nxt = stable_r + 1'b1;
      end
    end
    if (scan_done) begin
      prev_map_nxt = scan_map_nxt;
      if (!map_same) begin
        stable_nxt = '0;
      end
      if (map_settled) begin
        valid_map_nxt = scan_map_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_map_r  <= '0;
      prev_map_r  <= '0;
      valid_map_r <= '0;
      stable_r    <= '0;
    end else begin
      if (in_acc && !is_tick && row_ok) begin
        scan_map_r <= scan_map_nxt;
      end
      prev_map_r  <= prev_map_nxt;
      valid_map_r <= valid_map_nxt;
      stable_r    <= stable_nxt;
    end
  end

  // ---------------------------------------------------------------- action pick
  // Later matches overwrite earlier ones; play leaves the value untouched.
  action_kind_t      act_kind;
  logic [SLOT_W-1:0] act_val;

  always_comb begin
    act_kind = ACT_NONE;
    act_val  = '0;
    if (|up_edges) begin
      for (int i = 0; i < VIEW_SLOTS; i++) begin
        if (key_hit(up_edges, view_slots_r[i*SLOT_W +: SLOT_W])) begin
          act_kind = ACT_VIEW;
          act_val  = SLOT_W'(i);
        end
      end
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        if (key_hit(up_edges, note_slots_r[i*SLOT_W +: SLOT_W])) begin
          act_kind = ACT_NOTE_OFF;
          act_val  = SLOT_W'(i);
        end
      end
      if (key_hit(up_edges, ctrl_slots_r[CTRL_PLAY*SLOT_W +: SLOT_W])) begin
        act_kind = ACT_PLAY;
      end
      if (key_hit(up_edges, ctrl_slots_r[CTRL_OUP*SLOT_W +: SLOT_W])) begin
        act_kind = ACT_OCTAVE;
        act_val  = OCT_UP;
      end
      if (key_hit(up_edges, ctrl_slots_r[CTRL_ODN*SLOT_W +: SLOT_W])) begin
        act_kind = ACT_OCTAVE;
        act_val  = OCT_DOWN;
      end
    end
    if (|down_edges) begin
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        if (key_hit(down_edges, note_slots_r[i*SLOT_W +: SLOT_W])) begin
          act_kind = ACT_NOTE_ON;
          act_val  = SLOT_W'(i);
        end
      end
    end
  end

  result_t res_now;
  assign res_now = '{kind: act_kind, value: act_val,
                     pressed: down_edges, released: up_edges};

  // ---------------------------------------------------------------- output buffer
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_free;

  assign in_tready = !skid_valid_r;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // no transaction can arrive while the skid entry is full
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (scan_done) begin
        out_nxt       = res_now;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (scan_done) begin
      skid_nxt       = res_now;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {{(OUT_TDATA_W - SLOT_W - 2*MAP_W){1'b0}},
                       out_r.released, out_r.pressed, out_r.value};

  // ---------------------------------------------------------------- checks
  `KMDA_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `KMDA_ASSERT_NEXT(a_scan_gives_result, scan_done, out_valid_r, "completed scan left no result")
  `KMDA_ASSERT_NOW(a_edges_disjoint, out_valid_r, (out_r.pressed & out_r.released) == '0, "key both pressed and released")
  `KMDA_ASSERT_NEXT(a_valid_map_hold, !map_settled || !scan_done, $stable(valid_map_r), "valid map moved without a settled scan")

endmodule

`default_nettype wire

[tb/kmda_sb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard class for the keypad matrix scanner core: predicts one action result per scan.
// Depends on kmda_pkg for widths, codes and the result layout; used by tb_top.
package kmda_sb_pkg;
  import kmda_pkg::*;

  class keypad_scoreboard;
    // predicted block state
    logic [MAP_W-1:0]  scan_keys    = '0;
    logic [MAP_W-1:0]  last_keys    = '0;
    logic [MAP_W-1:0]  valid_keys   = '0;
    logic [DEB_W-1:0]  stable_count = '0;
    // register copies
    logic [DEB_W-1:0]  debounce   = DEBOUNCE_RST;
    logic [VIEW_W-1:0] view_slots = '0;
    logic [NOTE_W-1:0] note_slots = '0;
    logic [CTRL_W-1:0] ctrl_slots = '0;

    result_t action_q[$];
    int      mismatches = 0;

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_DEBOUNCE: debounce   = value[DEB_W-1:0];
        CFG_VIEW:     view_slots = value[VIEW_W-1:0];
        CFG_NOTE:     note_slots = value[NOTE_W-1:0];
        CFG_CONTROL:  ctrl_slots = value[CTRL_W-1:0];
        default: ;
      endcase
    endfunction

    // slot naming a key past the matrix never hits
    function bit slot_hit(logic [MAP_W-1:0] edges, logic [SLOT_W-1:0] key);
      if (int'(key) >= MAP_W) return 1'b0;
      return edges[key];
    endfunction

    function int pending();
      return action_q.size();
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Accepted input transaction: advance state, queue the result of a completed scan.
    function void note_item(in_kind_t kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] levels);
      logic [MAP_W-1:0] down;
      logic [MAP_W-1:0] up;
      result_t          res;
      down = '0;
      up   = '0;
      if (kind == KIND_TICK) begin
        if (stable_count != STABLE_MAX) stable_count++;
        return;
      end
      if (int'(row) >= ROWS) return;
      if (row == '0) scan_keys = '0;
      for (int j = 0; j < COLS; j++) begin
        if (!levels[j]) scan_keys[int'(row) * COLS + j] = 1'b1;
      end
      if (int'(row) != ROWS - 1) return;

      if (scan_keys == last_keys) begin
        if (stable_count >= debounce) begin
          down       = scan_keys & ~valid_keys;
          up         = ~scan_keys & valid_keys;
          valid_keys = scan_keys;
        end
      end else begin
        stable_count = '0;
      end
      last_keys = scan_keys;

      res.kind     = ACT_NONE;
      res.value    = '0;
      res.pressed  = down;
      res.released = up;
      // later matches override earlier ones; play keeps the earlier value
      if (up != '0) begin
        for (int i = 0; i < VIEW_SLOTS; i++) begin
          if (slot_hit(up, view_slots[i*SLOT_W +: SLOT_W])) begin
            res.kind  = ACT_VIEW;
            res.value = SLOT_W'(i);
          end
        end
        for (int i = 0; i < NOTE_SLOTS; i++) begin
          if (slot_hit(up, note_slots[i*SLOT_W +: SLOT_W])) begin
            res.kind  = ACT_NOTE_OFF;
            res.value = SLOT_W'(i);
          end
        end
        if (slot_hit(up, ctrl_slots[CTRL_PLAY*SLOT_W +: SLOT_W])) res.kind = ACT_PLAY;
        if (slot_hit(up, ctrl_slots[CTRL_OUP*SLOT_W +: SLOT_W])) begin
          res.kind  = ACT_OCTAVE;
          res.value = OCT_UP;
        end
        if (slot_hit(up, ctrl_slots[CTRL_ODN*SLOT_W +: SLOT_W])) begin
          res.kind  = ACT_OCTAVE;
          res.value = OCT_DOWN;
        end
      end
      if (down != '0) begin
        for (int i = 0; i < NOTE_SLOTS; i++) begin
          if (slot_hit(down, note_slots[i*SLOT_W +: SLOT_W])) begin
            res.kind  = ACT_NOTE_ON;
            res.value = SLOT_W'(i);
          end
        end
      end
      action_q.push_back(res);
    endfunction

    // Accepted output transaction: compare with the oldest predicted action.
    function void check_result(logic [2:0] tuser, logic [OUT_TDATA_W-1:0] tdata);
      result_t want;
      result_t got;
      got.kind     = action_kind_t'(tuser);
      got.value    = tdata[SLOT_W-1:0];
      got.pressed  = tdata[SLOT_W +: MAP_W];
      got.released = tdata[SLOT_W+MAP_W +: MAP_W];
      if (action_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: kind %0d value %0d pressed %05h released %05h",
                                  got.kind, got.value, got.pressed, got.released));
        return;
      end
      want = action_q.pop_front();
      if (got.kind != want.kind || got.value != want.value ||
          got.pressed != want.pressed || got.released != want.released ||
          tdata[OUT_TDATA_W-1:SLOT_W+2*MAP_W] != '0) begin
        report_mismatch($sformatf(
          "mismatch: exp kind %0d value %0d pressed %05h released %05h / got kind %0d value %0d pressed %05h released %05h pad %0h",
          want.kind, want.value, want.pressed, want.released,
          got.kind, got.value, got.pressed, got.released,
          tdata[OUT_TDATA_W-1:SLOT_W+2*MAP_W]));
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for keypad_matrix_debounce_actions_core: directed scans, then random phases.
// Depends on kmda_pkg and kmda_sb_pkg (scoreboard class).
module tb_top;
  import kmda_pkg::*;
  import kmda_sb_pkg::*;

  // far above the slowest correct run
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic                  in_tuser   = 1'b0;  // [0] kind
  logic [IN_TDATA_W-1:0] in_tdata   = '0;    // [2:0] row_index, [6:3] column_levels, [7] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2:0]            out_tuser;          // [2:0] action_kind
  logic [OUT_TDATA_W-1:0] out_tdata;         // [4:0] action_value, [24:5] pressed_edges,
                                             // [44:25] released_edges, [47:45] zero
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  keypad_matrix_debounce_actions_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keypad_scoreboard action_sb = new;

  // Watchdog: a hung handshake or a lost result ends the run here.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[keypad_matrix_debounce_actions_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. Signals are sampled right after the edge, so they still hold
  // the values seen by that edge. Ready follows a mode, re-drawn at random: always
  // ready, coin flip, or mostly stalled (fills the two-entry output buffer and
  // pushes back on the input).
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) action_sb.check_result(out_tuser, out_tdata);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int hot_keys[$];   // in-matrix keys named by the current slot registers

  // One input transaction. Bursts of random length, random gaps between them;
  // valid is only dropped when a gap really starts.
  task automatic send_item(in_kind_t kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] levels);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, levels, row};
    do @(posedge clk); while (!in_tready);
    action_sb.note_item(kind, row, levels);
    burst_left--;
  endtask

  // Tick content fields are don't-care; randomize them anyway.
  task automatic send_ticks(int count);
    repeat (count) send_item(KIND_TICK, ROW_W'($urandom), COL_W'($urandom));
  endtask

  // Rows 0..ROWS-1 for one key map (pressed = low column). With noise on, the
  // scan may skip row 0 (keys of the previous scan carry over), carry ticks and
  // out-of-range rows in the middle, or repeat a row with extra presses.
  task automatic send_scan(logic [MAP_W-1:0] keys, bit noisy);
    for (int r = 0; r < ROWS; r++) begin
      if (noisy && r == 0 && $urandom_range(0, 19) == 0) continue;
      if (noisy && $urandom_range(0, 11) == 0) send_ticks(1);
      if (noisy && $urandom_range(0, 14) == 0)
        send_item(KIND_ROW, ROW_W'($urandom_range(ROWS, 7)), COL_W'($urandom));
      send_item(KIND_ROW, ROW_W'(r), ~keys[r*COLS +: COLS]);
      if (noisy && r < ROWS - 1 && $urandom_range(0, 19) == 0)
        send_item(KIND_ROW, ROW_W'(r), COL_W'($urandom));
    end
  endtask

  // Key map for one scan, biased toward keys that have an action.
  function automatic logic [MAP_W-1:0] pick_map();
    logic [MAP_W-1:0] m;
    int               n;
    m = '0;
    case ($urandom_range(0, 9))
      0: m = MAP_W'($urandom);
      1: m = '0;
      2: m = '1;
      3: m[$urandom_range(0, MAP_W - 1)] = 1'b1;
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          if (hot_keys.size() > 0) m[hot_keys[$urandom_range(0, hot_keys.size() - 1)]] = 1'b1;
          else m[$urandom_range(0, MAP_W - 1)] = 1'b1;
        end
      end
    endcase
    return m;
  endfunction

  // Slot fields: mostly keys inside the matrix, some past it (never match).
  function automatic logic [NOTE_W-1:0] rand_slots(int count);
    logic [NOTE_W-1:0] v;
    v = '0;
    for (int i = 0; i < count; i++) begin
      v[i*SLOT_W +: SLOT_W] = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(MAP_W, 31))
                                                          : SLOT_W'($urandom_range(0, MAP_W - 1));
    end
    return v;
  endfunction

  // Write all four registers on back-to-back cycles; only called while idle.
  task automatic apply_config(logic [DEB_W-1:0] deb, logic [VIEW_W-1:0] view,
                              logic [NOTE_W-1:0] note, logic [CTRL_W-1:0] ctrl);
    cfg_reg_t                        regs [4];
    logic [CFG_DATA_W-1:0]           vals [4];
    logic [VIEW_W+NOTE_W+CTRL_W-1:0] slots;
    regs = '{CFG_DEBOUNCE, CFG_VIEW, CFG_NOTE, CFG_CONTROL};
    vals = '{CFG_DATA_W'(deb), CFG_DATA_W'(view), CFG_DATA_W'(note), CFG_DATA_W'(ctrl)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      action_sb.write_reg(regs[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    slots = {ctrl, note, view};
    hot_keys.delete();
    for (int k = 0; k < VIEW_SLOTS + NOTE_SLOTS + CTRL_SLOTS; k++) begin
      if (int'(slots[k*SLOT_W +: SLOT_W]) < MAP_W)
        hot_keys.push_back(int'(slots[k*SLOT_W +: SLOT_W]));
    end
  endtask

  // Stop sending, let every expected result drain, then allow for in-flight
  // items that produce no result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (action_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random scans against the current debounce setting. A held map is rescanned
  // most of the time so it gets accepted; it changes now and then, and some
  // scans are one-off bounces. Tick counts mostly reach the debounce time,
  // sometimes fall short of it.
  task automatic run_scans(int n_scans);
    logic [MAP_W-1:0] held;
    int               choice;
    int               ticks;
    int               deb;
    deb  = int'(action_sb.debounce);
    held = pick_map();
    repeat (n_scans) begin
      choice = $urandom_range(0, 9);
      if (choice < 3) held = pick_map();
      if ($urandom_range(0, 3) != 0) ticks = deb + $urandom_range(0, 3);
      else ticks = $urandom_range(0, deb);
      send_ticks(ticks);
      send_scan((choice == 3) ? pick_map() : held, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [VIEW_W-1:0] view;
    logic [NOTE_W-1:0] note;
    logic [CTRL_W-1:0] ctrl;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: views on keys 15..19, notes on keys 0..11, play/up/down on 12..14,
    // no debounce wait.
    for (int i = 0; i < VIEW_SLOTS; i++) view[i*SLOT_W +: SLOT_W] = SLOT_W'(15 + i);
    for (int i = 0; i < NOTE_SLOTS; i++) note[i*SLOT_W +: SLOT_W] = SLOT_W'(i);
    ctrl = {5'd14, 5'd13, 5'd12};
    apply_config('0, view, note, ctrl);
    send_item(KIND_TICK, 3'd0, 4'h0);
    send_item(KIND_TICK, 3'd7, 4'hF);
    // rows past the matrix are dropped
    send_item(KIND_ROW, 3'd5, 4'h0);
    send_item(KIND_ROW, 3'd7, 4'hF);
    // all keys down: first scan only restarts the counter, second is accepted
    repeat (2) send_scan('1, 1'b0);
    // all keys up: every release matches, octave down wins
    repeat (2) send_scan('0, 1'b0);

    // Random phases; the extremes of each register appear at least once.
    wait_idle();
    apply_config('0, VIEW_W'(rand_slots(VIEW_SLOTS)), rand_slots(NOTE_SLOTS),
                 CTRL_W'(rand_slots(CTRL_SLOTS)));
    run_scans(15);

    wait_idle();
    apply_config(DEBOUNCE_RST, VIEW_W'(rand_slots(VIEW_SLOTS)), rand_slots(NOTE_SLOTS),
                 CTRL_W'(rand_slots(CTRL_SLOTS)));
    run_scans(10);

    // longest debounce; every slot past the matrix. The counter saturates at its
    // top, then the held map is accepted on both following scans.
    wait_idle();
    apply_config(STABLE_MAX, '1, '1, '1);
    send_scan('1, 1'b0);
    send_ticks(int'(STABLE_MAX) + 4);
    repeat (2) send_scan('1, 1'b0);

    // every slot on key 0: press gives note on 11, release gives octave down
    wait_idle();
    apply_config(DEB_W'($urandom_range(1, 6)), '0, '0, '0);
    run_scans(10);

    wait_idle();
    apply_config(DEB_W'($urandom_range(0, 3)), VIEW_W'(rand_slots(VIEW_SLOTS)),
                 rand_slots(NOTE_SLOTS), CTRL_W'(rand_slots(CTRL_SLOTS)));
    run_scans(10);

    wait_idle();
    if (action_sb.mismatches == 0 && action_sb.pending() == 0) begin
      $display("[keypad_matrix_debounce_actions_core] OK");
    end else begin
      $display("[keypad_matrix_debounce_actions_core] ERROR");
    end
    $finish;
  end

endmodule
